[rtl/core/bcs_pkg.sv]
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared widths, limits, codes and state type of the Bezier curve sampler.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int unsigned MAX_POINTS  = 16;
  localparam int unsigned MAX_RESULTS = 48;

  localparam int unsigned XY_W   = 32;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned T_W    = 16;
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned TOT_W  = $clog2(MAX_RESULTS + 1);
  localparam int unsigned DIV_W  = CNT_W + 2;
  localparam int unsigned REM_W  = DIV_W + 1;
  localparam int unsigned DCNT_W = $clog2(T_W);
  localparam int unsigned DIFF_W = XY_W + 1;
  localparam int unsigned PROD_W = DIFF_W + T_W + 1;

  localparam logic [TAG_W-1:0]  TAG_NONE   = '1;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (T_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_RD0,
    ST_ALD,
    ST_BLD,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } bcs_state_e;

endpackage

[rtl/core/bcs_pt_if.sv]
// ----------------------------------------------------------------------------
// bcs_pt_if
// Control point channel: valid/ready with x, y, tag and end-of-curve flag.
// ----------------------------------------------------------------------------
interface bcs_pt_if import bcs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [XY_W-1:0]  pt_x;
  logic signed [XY_W-1:0]  pt_y;
  logic signed [TAG_W-1:0] pt_tag;
  logic                    pt_last;

  modport source (output valid, output pt_x, output pt_y, output pt_tag, output pt_last,
                  input ready);
  modport sink   (input valid, input pt_x, input pt_y, input pt_tag, input pt_last,
                  output ready);
endinterface

[rtl/core/bcs_smp_if.sv]
// ----------------------------------------------------------------------------
// bcs_smp_if
// Curve sample channel: valid/ready with x, y, tag and end-of-curve flag.
// ----------------------------------------------------------------------------
interface bcs_smp_if import bcs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [XY_W-1:0]  smp_x;
  logic signed [XY_W-1:0]  smp_y;
  logic signed [TAG_W-1:0] smp_tag;
  logic                    smp_last;

  modport source (output valid, output smp_x, output smp_y, output smp_tag,
                  output smp_last, input ready);
  modport sink   (input valid, input smp_x, input smp_y, input smp_tag,
                  input smp_last, output ready);
endinterface

[rtl/core/bezier_curve_sampler.sv]
// ----------------------------------------------------------------------------
// bezier_curve_sampler
// De Casteljau sampler: loads control points, emits 3n samples per curve.
// ----------------------------------------------------------------------------
// Control point words are taken one per cycle while the block is idle and are
// stored in small x/y memories (points past MAX_POINTS are dropped). The word
// flagged pt_last starts evaluation of the stored n points; the input then
// stays not ready until the last sample has been loaded into the output
// register. Sample 0 is the first point with its own tag; sample i > 0 is the
// curve at t = floor(i * 65536 / 3n) with tag -1, and smp_last marks the final
// sample (at most MAX_RESULTS per curve). Every lerp runs on one shared lerp
// unit (subtract, 33x17 multiply, round-and-add), so a sample i > 0 first
// runs the bit-serial divider for t, then n - 1 rounds of lerps per axis,
// each round starting with a fetch of its first entry. Sample 0, and every
// sample of a one-point curve, skips the divider and the lerps. A finished
// sample waits in the output register while the next one is computed.
// ----------------------------------------------------------------------------
module bezier_curve_sampler import bcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bcs_pt_if.sink    pt_i,
  bcs_smp_if.source smp_o
);

  // Sequencer and counters
  bcs_state_e             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;       // points stored for current curve
  logic [CNT_W-1:0]       n_q, n_d;           // points of curve under evaluation
  logic [DIV_W-1:0]       d_q, d_d;           // 3n, divisor for t
  logic [TOT_W-1:0]       total_q, total_d;
  logic [TOT_W-1:0]       i_q, i_d;           // sample index
  logic [CNT_W-1:0]       m_q, m_d;           // entries alive in current round
  logic [IDX_W-1:0]       k_q, k_d;           // lerp index within round
  logic                   axis_q, axis_d;     // 0: x, 1: y
  logic [DCNT_W-1:0]      dcnt_q, dcnt_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [T_W-1:0]         t_q, t_d;
  logic [TAG_W-1:0]       first_tag_q, first_tag_d;
  logic                   out_valid_q, out_valid_d;

  // Datapath registers
  logic signed [XY_W-1:0]   a_q, a_d;
  logic signed [XY_W-1:0]   b_q, b_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [XY_W-1:0]   sx_q, sx_d;
  logic signed [XY_W-1:0]   out_x_q, out_x_d;
  logic signed [XY_W-1:0]   out_y_q, out_y_d;
  logic [TAG_W-1:0]         out_tag_q, out_tag_d;
  logic                     out_last_q, out_last_d;
  logic signed [XY_W-1:0]   sy_q, sy_d;

  // Memories
  logic signed [XY_W-1:0] ctrl_x_mem [MAX_POINTS];
  logic signed [XY_W-1:0] ctrl_y_mem [MAX_POINTS];
  logic signed [XY_W-1:0] work_mem   [MAX_POINTS];
  logic signed [XY_W-1:0] ctrl_x_rd_q, ctrl_y_rd_q, work_rd_q;

  logic                   pt_we, wk_we;
  logic [IDX_W-1:0]       rd_addr;

  // Combinational helpers
  logic                   pt_acc, out_acc, pass, round_first;
  logic signed [XY_W-1:0] rd_data, lerp_res, axis_val;
  logic                   axis_done;
  logic [PROD_W-1:0]      rnd;
  logic [REM_W-1:0]       rem_sh;
  logic [CNT_W-1:0]       n_new;
  logic [DIV_W-1:0]       three_n;

  assign pt_acc  = pt_i.valid && pt_i.ready;
  assign out_acc = smp_o.valid && smp_o.ready;

  assign pt_i.ready     = (state_q == ST_IDLE);
  assign smp_o.valid    = out_valid_q;
  assign smp_o.smp_x    = out_x_q;
  assign smp_o.smp_y    = out_y_q;
  assign smp_o.smp_tag  = out_tag_q;
  assign smp_o.smp_last = out_last_q;

  // Sample 0 and one-point curves take the first point as is
  assign pass        = (i_q == '0) || (n_q == CNT_W'(1));
  assign round_first = (m_q == n_q);
  assign rd_data     = !round_first ? work_rd_q : (axis_q ? ctrl_y_rd_q : ctrl_x_rd_q);

  // Lerp back end: a + round_half_up((b - a) * t / 2^16)
  assign rnd      = prod_q + ROUND_HALF;
  assign lerp_res = a_q + rnd[T_W+XY_W-1:T_W];

  assign rem_sh  = {rem_q[REM_W-2:0], 1'b0};
  assign n_new   = (cnt_q < CNT_W'(MAX_POINTS)) ? cnt_q + CNT_W'(1) : cnt_q;
  assign three_n = DIV_W'(n_new) + (DIV_W'(n_new) << 1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    d_d         = d_q;
    total_d     = total_q;
    i_d         = i_q;
    m_d         = m_q;
    k_d         = k_q;
    axis_d      = axis_q;
    dcnt_d      = dcnt_q;
    rem_d       = rem_q;
    t_d         = t_q;
    first_tag_d = first_tag_q;
    out_valid_d = out_valid_q && !out_acc;
    a_d         = a_q;
    b_d         = b_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_tag_d   = out_tag_q;
    out_last_d  = out_last_q;
    pt_we       = 1'b0;
    wk_we       = 1'b0;
    rd_addr     = '0;
    axis_done   = 1'b0;
    axis_val    = lerp_res;

    case (state_q)
      ST_IDLE: begin
        if (pt_acc) begin
          if (cnt_q < CNT_W'(MAX_POINTS)) begin
            pt_we = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
            if (cnt_q == '0) begin
              first_tag_d = pt_i.pt_tag;
            end
          end
          if (pt_i.pt_last) begin
            n_d     = n_new;
            d_d     = three_n;
            total_d = (three_n > DIV_W'(MAX_RESULTS)) ? TOT_W'(MAX_RESULTS)
                                                      : TOT_W'(three_n);
            cnt_d   = '0;
            i_d     = '0;
            state_d = ST_START;
          end
        end
      end

      ST_START: begin
        axis_d = 1'b0;
        m_d    = n_q;
        k_d    = '0;
        if (pass) begin
          state_d = ST_RD0;
        end else begin
          rem_d   = REM_W'(i_q);
          dcnt_d  = '0;
          state_d = ST_DIV;
        end
      end

      // Restoring division, one quotient bit a cycle; i < 3n so rem starts at i
      ST_DIV: begin
        if (rem_sh >= REM_W'(d_q)) begin
          rem_d = rem_sh - REM_W'(d_q);
          t_d   = {t_q[T_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          t_d   = {t_q[T_W-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(T_W - 1)) begin
          state_d = ST_RD0;
        end
      end

      ST_RD0: begin
        rd_addr = '0;
        state_d = ST_ALD;
      end

      ST_ALD: begin
        if (pass) begin
          axis_done = 1'b1;
          axis_val  = rd_data;
        end else begin
          a_d     = rd_data;
          k_d     = '0;
          rd_addr = IDX_W'(1);
          state_d = ST_BLD;
        end
      end

      ST_BLD: begin
        b_d     = rd_data;
        diff_d  = DIFF_W'(rd_data) - DIFF_W'(a_q);
        state_d = ST_MUL;
      end

      ST_MUL: begin
        prod_d  = diff_q * $signed({1'b0, t_q});
        state_d = ST_ACC;
      end

      ST_ACC: begin
        wk_we = 1'b1;
        a_d   = b_q;
        if (CNT_W'(k_q) == m_q - CNT_W'(2)) begin
          if (m_q == CNT_W'(2)) begin
            axis_done = 1'b1;
          end else begin
            m_d     = m_q - CNT_W'(1);
            state_d = ST_RD0;
          end
        end else begin
          k_d     = k_q + IDX_W'(1);
          rd_addr = IDX_W'(CNT_W'(k_q) + CNT_W'(2));
          state_d = ST_BLD;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || out_acc) begin
          out_valid_d = 1'b1;
          out_x_d     = sx_q;
          out_y_d     = sy_q;
          out_tag_d   = (i_q == '0) ? first_tag_q : TAG_NONE;
          out_last_d  = (i_q == total_q - TOT_W'(1));
          if (i_q == total_q - TOT_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + TOT_W'(1);
            state_d = ST_START;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Axis finished: x moves on to y, y moves on to the output register
    if (axis_done) begin
      if (!axis_q) begin
        sx_d    = axis_val;
        axis_d  = 1'b1;
        m_d     = n_q;
        state_d = ST_RD0;
      end else begin
        sy_d    = axis_val;
        state_d = ST_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      d_q         <= '0;
      total_q     <= '0;
      i_q         <= '0;
      m_q         <= '0;
      k_q         <= '0;
      axis_q      <= 1'b0;
      dcnt_q      <= '0;
      first_tag_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      d_q         <= d_d;
      total_q     <= total_d;
      i_q         <= i_d;
      m_q         <= m_d;
      k_q         <= k_d;
      axis_q      <= axis_d;
      dcnt_q      <= dcnt_d;
      first_tag_q <= first_tag_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    t_q        <= t_d;
    a_q        <= a_d;
    b_q        <= b_d;
    diff_q     <= diff_d;
    prod_q     <= prod_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_tag_q  <= out_tag_d;
    out_last_q <= out_last_d;
  end

  // Control point stores
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      ctrl_x_mem[cnt_q[IDX_W-1:0]] <= pt_i.pt_x;
      ctrl_y_mem[cnt_q[IDX_W-1:0]] <= pt_i.pt_y;
    end
    ctrl_x_rd_q <= ctrl_x_mem[rd_addr];
    ctrl_y_rd_q <= ctrl_y_mem[rd_addr];
  end

  // Working row of the de Casteljau triangle
  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      work_mem[k_q] <= lerp_res;
    end
    work_rd_q <= work_mem[rd_addr];
  end

endmodule
